// ===== sv/knxfp_pkg.sv =====
// -----------------------------------------------------------------------------
// knxfp_pkg
// Shared types, codes and constants of the standard frame parser.
// -----------------------------------------------------------------------------
package knxfp_pkg;

   // tdata widths of both channels
   localparam int unsigned ReqDataWidth = 8;
   localparam int unsigned RspDataWidth = 72;
   localparam int unsigned RspUsedWidth = 67;

   // shortest legal frame, counted with the checksum octet
   localparam logic [4:0] MinFrameLen   = 5'd8;
   // longest count the octet counter holds
   localparam logic [4:0] MaxByteCount  = 5'd31;
   // expected frame length is this plus the routing length nibble
   localparam logic [4:0] FrameOverhead = 5'd8;

   localparam logic [7:0] ChecksumGood  = 8'hFF;
   localparam logic [7:0] PrioMask      = 8'h0C;
   localparam logic [7:0] ClassMask     = 8'hC0;
   localparam logic [7:0] ClassData     = 8'h00;
   localparam logic [7:0] ClassConnData = 8'h40;
   localparam logic [7:0] CtrlConnect   = 8'h80;
   localparam logic [7:0] CtrlDisconn   = 8'h81;
   localparam logic [7:0] AckMask       = 8'hC3;
   localparam logic [7:0] CtrlAck       = 8'hC2;
   localparam logic [7:0] CtrlNak       = 8'hC3;

   // header octet positions captured from the stream
   localparam logic [4:0] IdxControl    = 5'd0;
   localparam logic [4:0] IdxSourceHi   = 5'd1;
   localparam logic [4:0] IdxSourceLo   = 5'd2;
   localparam logic [4:0] IdxTargetHi   = 5'd3;
   localparam logic [4:0] IdxTargetLo   = 5'd4;
   localparam logic [4:0] IdxRouting    = 5'd5;
   localparam logic [4:0] IdxTransport  = 5'd6;
   localparam logic [4:0] IdxServiceLo  = 5'd7;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_RUNT     = 2'd1,
      STATUS_CHECKSUM = 2'd2,
      STATUS_LENGTH   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      TCLASS_DATA_GROUP = 3'd0,
      TCLASS_DATA_INDIV = 3'd1,
      TCLASS_CONNECTED  = 3'd2,
      TCLASS_CONNECT    = 3'd3,
      TCLASS_DISCONNECT = 3'd4,
      TCLASS_ACK        = 3'd5,
      TCLASS_NAK        = 3'd6,
      TCLASS_UNKNOWN    = 3'd7
   } tclass_type;

   typedef enum logic [1:0] {
      SVC_READ     = 2'd0,
      SVC_RESPONSE = 2'd1,
      SVC_WRITE    = 2'd2,
      SVC_UNKNOWN  = 2'd3
   } svc_type;

   // one octet of the frame as held in the input register
   typedef struct packed {
      logic       last_byte;
      logic [7:0] frame_byte;
   } octet_type;

   // frame state after the current octet has been folded in
   typedef struct packed {
      logic [4:0]  byte_count;
      logic [7:0]  running_xor;
      logic [7:0]  control_octet;
      logic [15:0] source_word;
      logic [15:0] target_word;
      logic [7:0]  routing_octet;
      logic [7:0]  transport_octet;
      logic [7:0]  service_low_octet;
   } frame_snap_type;

   // handshake between the input register and the accumulator
   typedef struct packed {
      logic valid;
      logic take;
   } stage_ctrl_type;

   // decoded result fields
   typedef struct packed {
      logic [3:0]  payload_length;
      logic [5:0]  inline_data;
      svc_type     service_type;
      logic [9:0]  service_code;
      logic        has_service;
      logic [3:0]  sequence_number;
      tclass_type  transport_class;
      logic        group_target;
      logic [15:0] target_address;
      logic [15:0] source_address;
      logic [1:0]  priority_res;
      status_type  status;
   } result_type;

endpackage

// ===== sv/knxfp_in_stage.sv =====
// -----------------------------------------------------------------------------
// knxfp_in_stage
// Input register: holds one accepted octet until the accumulator takes it.
// -----------------------------------------------------------------------------
module knxfp_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,   // [7:0] frame_byte
   input  logic                req_tlast,   // last_byte
   input  logic                take,        // accumulator consumes the octet
   output knxfp_pkg::octet_type     octet,
   output knxfp_pkg::stage_ctrl_type ctrl_out
);
   import knxfp_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   octet_type octet_ff;
   logic      accept;

   // free, or being emptied this cycle
   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;

   // occupancy
   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         octet_ff.frame_byte <= req_tdata;
         octet_ff.last_byte  <= req_tlast;
      end
   end

   assign octet          = octet_ff;
   assign ctrl_out.valid = valid_ff;
   assign ctrl_out.take  = take;

endmodule

// ===== sv/knxfp_frame_acc.sv =====
// -----------------------------------------------------------------------------
// knxfp_frame_acc
// Frame accumulator: octet count, running XOR and captured header octets.
// Presents the state with the current octet folded in; clears on the last.
// -----------------------------------------------------------------------------
module knxfp_frame_acc (
   input  logic                      clock,
   input  logic                      reset,
   input  knxfp_pkg::stage_ctrl_type ctrl_in,
   input  knxfp_pkg::octet_type      octet,
   output knxfp_pkg::frame_snap_type snap
);
   import knxfp_pkg::*;

   frame_snap_type state_ff;
   frame_snap_type state_in;
   frame_snap_type upd;

   // fold the current octet into the state
   always_comb begin
      upd = state_ff;
      unique case (state_ff.byte_count)
         IdxControl:   upd.control_octet        = octet.frame_byte;
         IdxSourceHi:  upd.source_word[15:8]    = octet.frame_byte;
         IdxSourceLo:  upd.source_word[7:0]     = octet.frame_byte;
         IdxTargetHi:  upd.target_word[15:8]    = octet.frame_byte;
         IdxTargetLo:  upd.target_word[7:0]     = octet.frame_byte;
         IdxRouting:   upd.routing_octet        = octet.frame_byte;
         IdxTransport: upd.transport_octet      = octet.frame_byte;
         IdxServiceLo: upd.service_low_octet    = octet.frame_byte;
         default:      upd.control_octet        = state_ff.control_octet;
      endcase
      upd.running_xor = state_ff.running_xor ^ octet.frame_byte;
      if (state_ff.byte_count != MaxByteCount) begin
         upd.byte_count = state_ff.byte_count + 5'd1;
      end
   end

   // commit; a frame end returns everything to zero
   always_comb begin
      state_in = state_ff;
      if (ctrl_in.take) begin
         if (octet.last_byte) begin
            state_in = '0;
         end else begin
            state_in = upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign snap = upd;

endmodule

// ===== sv/knxfp_result_stage.sv =====
// -----------------------------------------------------------------------------
// knxfp_result_stage
// Checks and decodes a completed frame and holds the result for the receiver.
// -----------------------------------------------------------------------------
module knxfp_result_stage (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,       // last octet taken this cycle
   input  knxfp_pkg::frame_snap_type snap,
   input  logic                      rsp_tready,
   output logic                      rsp_tvalid,
   output knxfp_pkg::result_type     result
);
   import knxfp_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;
   result_type res_in;
   logic [7:0] tr;
   logic [3:0] lg;
   logic [3:0] cmd;
   logic [4:0] expect_len;

   assign tr         = snap.transport_octet;
   assign lg         = snap.routing_octet[3:0];
   assign cmd        = {tr[1:0], snap.service_low_octet[7:6]};
   assign expect_len = {1'b0, lg} + FrameOverhead;

   // frame checks and field decode
   always_comb begin
      res_in = '0;
      priority if (snap.byte_count < MinFrameLen) begin
         res_in.status = STATUS_RUNT;
      end else if (snap.running_xor != ChecksumGood) begin
         res_in.status = STATUS_CHECKSUM;
      end else if (snap.byte_count != expect_len) begin
         res_in.status = STATUS_LENGTH;
      end else begin
         res_in.status         = STATUS_OK;
         res_in.priority_res   = 2'((snap.control_octet & PrioMask) >> 2);
         res_in.source_address = snap.source_word;
         res_in.target_address = snap.target_word;
         res_in.group_target   = snap.routing_octet[7];
         // transport control field
         priority if ((tr & ClassMask) == ClassData) begin
            res_in.transport_class = snap.routing_octet[7] ? TCLASS_DATA_GROUP
                                                           : TCLASS_DATA_INDIV;
         end else if ((tr & ClassMask) == ClassConnData) begin
            res_in.transport_class = TCLASS_CONNECTED;
            res_in.sequence_number = tr[5:2];
         end else if (tr == CtrlConnect) begin
            res_in.transport_class = TCLASS_CONNECT;
         end else if (tr == CtrlDisconn) begin
            res_in.transport_class = TCLASS_DISCONNECT;
         end else if ((tr & AckMask) == CtrlAck) begin
            res_in.transport_class = TCLASS_ACK;
            res_in.sequence_number = tr[5:2];
         end else if ((tr & AckMask) == CtrlNak) begin
            res_in.transport_class = TCLASS_NAK;
            res_in.sequence_number = tr[5:2];
         end else begin
            res_in.transport_class = TCLASS_UNKNOWN;
         end
         // application control field, absent for a one-octet data unit
         if (lg == 4'd0) begin
            res_in.service_type = SVC_UNKNOWN;
         end else begin
            res_in.has_service  = 1'b1;
            res_in.service_code = {tr[1:0], snap.service_low_octet};
            res_in.service_type = (cmd <= 4'd2) ? svc_type'(cmd[1:0]) : SVC_UNKNOWN;
            if (lg == 4'd1) begin
               res_in.inline_data = snap.service_low_octet[5:0];
            end else begin
               res_in.payload_length = lg - 4'd1;
            end
         end
      end
   end

   // output register occupancy
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= res_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign result     = result_ff;

endmodule

// ===== sv/knx_frame_parser.sv =====
// -----------------------------------------------------------------------------
// knx_frame_parser
// Standard frame parser: octets in, one checked and decoded result per frame.
// -----------------------------------------------------------------------------
// Usage:
//   req_* carries the frame one octet per transaction, control octet first;
//   req_tlast marks the checksum octet that closes the frame.
//   rsp_* carries one result per frame, issued after the closing octet.
//   Octets are registered on entry in the input register, then folded into
//   the frame state; a closing octet loads the result register in the same
//   cycle as it is folded in, which makes the result valid.
//   Throughput is one octet per cycle; the only stall path is the result
//   register, which holds a result until it is taken. Octets that do not
//   close a frame keep flowing while a result waits; a closing octet waits in
//   the input register until the result register is free.
//   Reset clears both registers' valid flags and all frame state; no
//   initialisation pass is needed. Frame state clears after each closing
//   octet, so frames follow back to back.
// -----------------------------------------------------------------------------
module knx_frame_parser (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] frame_byte
   input  logic         req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [1:0] status, [3:2] priority_res, [19:4] source_address,
   // [35:20] target_address, [36] group_target, [39:37] transport_class,
   // [43:40] sequence_number, [44] has_service, [54:45] service_code,
   // [56:55] service_type, [62:57] inline_data, [66:63] payload_length,
   // [71:67] zero
   output logic [71:0]  rsp_tdata
);
   import knxfp_pkg::*;

   octet_type      octet;
   stage_ctrl_type in_ctrl;
   frame_snap_type snap;
   result_type     result;
   logic           out_free;
   logic           take;
   logic           load;

   // a non-closing octet never needs the result register
   assign out_free = !rsp_tvalid || rsp_tready;
   assign take     = in_ctrl.valid && (!octet.last_byte || out_free);
   assign load     = take && octet.last_byte;

   knxfp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .take       (take),
      .octet      (octet),
      .ctrl_out   (in_ctrl)
   );

   knxfp_frame_acc u_frame_acc (
      .clock   (clock),
      .reset   (reset),
      .ctrl_in (in_ctrl),
      .octet   (octet),
      .snap    (snap)
   );

   knxfp_result_stage u_result_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .snap       (snap),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .result     (result)
   );

   // pack result fields, status lowest, zero padding highest
   assign rsp_tdata = {{(RspDataWidth - RspUsedWidth){1'b0}},
                       result.payload_length,
                       result.inline_data,
                       result.service_type,
                       result.service_code,
                       result.has_service,
                       result.sequence_number,
                       result.transport_class,
                       result.group_target,
                       result.target_address,
                       result.source_address,
                       result.priority_res,
                       result.status};

endmodule

// ===== sv/knxfp_checker.sv =====
// -----------------------------------------------------------------------------
// knxfp_checker
// Port-level checks of the frame parser, bound to the top level.
// -----------------------------------------------------------------------------
module knxfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [7:0]  req_tdata,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);
   import knxfp_pkg::*;

   logic ok_result;
   logic no_service;

   assign ok_result  = rsp_tvalid && (rsp_tdata[1:0] == STATUS_OK);
   assign no_service = ok_result && !rsp_tdata[44];

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a pending result is not dropped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result withdrawn while stalled");

   // an error result carries nothing but its status
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] != STATUS_OK) |-> (rsp_tdata[71:2] == '0))
      else $error("error result has non-zero fields");

   // without an application control field the service fields are defaults
   a_no_service: assert property (@(posedge clock) disable iff (reset)
      no_service |-> (rsp_tdata[54:45] == '0) && (rsp_tdata[56:55] == SVC_UNKNOWN)
                     && (rsp_tdata[66:57] == '0))
      else $error("service fields set without a service");

endmodule

bind knx_frame_parser knxfp_checker u_knxfp_checker (.*);

// ===== tb/sv/knxfp_frame_checker.sv =====
// -----------------------------------------------------------------------------
// knxfp_frame_checker
// Watches both streams of the frame parser, predicts the result of every
// frame and compares each result transaction field by field.
// -----------------------------------------------------------------------------
// Every accepted octet is folded into a private copy of the frame state; the
// closing octet turns that state into an expected result, queued in order.
// Each accepted result is checked against the oldest queued one. Failures are
// counted and handed to the testbench top together with the queue depth.
// -----------------------------------------------------------------------------
module knxfp_frame_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,
   output int          failures,
   output int          outstanding
);

   timeunit 1ns;
   timeprecision 1ps;

   import knxfp_pkg::*;

   frame_snap_type frame_state;
   result_type     pending_results[$];
   int             error_count = 0;

   initial outstanding = 0;
   assign failures = error_count;

   // capture the header octet at the current position, XOR it in and count it
   function automatic frame_snap_type fold_octet(frame_snap_type s, logic [7:0] octet);
      case (s.byte_count)
         IdxControl:   s.control_octet          = octet;
         IdxSourceHi:  s.source_word[15:8]      = octet;
         IdxSourceLo:  s.source_word[7:0]       = octet;
         IdxTargetHi:  s.target_word[15:8]      = octet;
         IdxTargetLo:  s.target_word[7:0]       = octet;
         IdxRouting:   s.routing_octet          = octet;
         IdxTransport: s.transport_octet        = octet;
         IdxServiceLo: s.service_low_octet      = octet;
         default: ;
      endcase
      s.running_xor = s.running_xor ^ octet;
      if (s.byte_count != MaxByteCount)
         s.byte_count = s.byte_count + 5'd1;
      return s;
   endfunction

   // checks in order runt, checksum, length; then decode of a good frame
   function automatic result_type decode_frame(frame_snap_type s);
      result_type r;
      logic [3:0] lg;
      logic [7:0] t;
      logic [9:0] code;
      logic [3:0] cmd;
      logic       group;
      r     = '0;
      lg    = s.routing_octet[3:0];
      t     = s.transport_octet;
      group = s.routing_octet[7];
      if (s.byte_count < MinFrameLen) begin
         r.status = STATUS_RUNT;
      end else if (s.running_xor != ChecksumGood) begin
         r.status = STATUS_CHECKSUM;
      end else if (s.byte_count != FrameOverhead + 5'(lg)) begin
         r.status = STATUS_LENGTH;
      end else begin
         r.status         = STATUS_OK;
         r.priority_res   = 2'((s.control_octet & PrioMask) >> 2);
         r.source_address = s.source_word;
         r.target_address = s.target_word;
         r.group_target   = group;
         // transport class; sequence only for connected data, ack and nak
         if ((t & ClassMask) == ClassData) begin
            r.transport_class = group ? TCLASS_DATA_GROUP : TCLASS_DATA_INDIV;
         end else if ((t & ClassMask) == ClassConnData) begin
            r.transport_class = TCLASS_CONNECTED;
            r.sequence_number = t[5:2];
         end else if (t == CtrlConnect) begin
            r.transport_class = TCLASS_CONNECT;
         end else if (t == CtrlDisconn) begin
            r.transport_class = TCLASS_DISCONNECT;
         end else if ((t & AckMask) == CtrlAck) begin
            r.transport_class = TCLASS_ACK;
            r.sequence_number = t[5:2];
         end else if ((t & AckMask) == CtrlNak) begin
            r.transport_class = TCLASS_NAK;
            r.sequence_number = t[5:2];
         end else begin
            r.transport_class = TCLASS_UNKNOWN;
         end
         // a one-octet data unit carries no service
         if (lg == 4'd0) begin
            r.service_type = SVC_UNKNOWN;
         end else begin
            code          = {t[1:0], s.service_low_octet};
            cmd           = code[9:6];
            r.has_service  = 1'b1;
            r.service_code = code;
            if (cmd <= 4'(SVC_WRITE))
               r.service_type = svc_type'(cmd[1:0]);
            else
               r.service_type = SVC_UNKNOWN;
            if (lg == 4'd1)
               r.inline_data = s.service_low_octet[5:0];
            else
               r.payload_length = lg - 4'd1;
         end
      end
      return r;
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   // result side first: a result never belongs to an octet of the same edge
   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         frame_state = '0;
         pending_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[66:0]);
            if (pending_results.size() == 0) begin
               $error("result transaction with no frame outstanding: 0x%0h", rsp_tdata);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               check_field("status",          want.status,          got.status);
               check_field("priority_res",    want.priority_res,    got.priority_res);
               check_field("source_address",  want.source_address,  got.source_address);
               check_field("target_address",  want.target_address,  got.target_address);
               check_field("group_target",    want.group_target,    got.group_target);
               check_field("transport_class", want.transport_class, got.transport_class);
               check_field("sequence_number", want.sequence_number, got.sequence_number);
               check_field("has_service",     want.has_service,     got.has_service);
               check_field("service_code",    want.service_code,    got.service_code);
               check_field("service_type",    want.service_type,    got.service_type);
               check_field("inline_data",     want.inline_data,     got.inline_data);
               check_field("payload_length",  want.payload_length,  got.payload_length);
               check_field("padding",         16'd0,                rsp_tdata[71:67]);
            end
         end
         if (req_tvalid && req_tready) begin
            frame_state = fold_octet(frame_state, req_tdata);
            if (req_tlast) begin
               pending_results.push_back(decode_frame(frame_state));
               frame_state = '0;
            end
         end
      end
      outstanding <= pending_results.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
// -----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the standard frame parser.
// -----------------------------------------------------------------------------
// Sends a directed set of frames (runts, each transport class, inline and
// payload data units, bad checksum, bad length, over-long frame), then random
// frames, mostly well formed with random content, the rest broken or noise.
// Both sides insert random gaps, with quiet stretches; the receiver holds off
// for long stretches so that the parser stalls its input. Checking is done by
// the frame checker beside the parser.
// -----------------------------------------------------------------------------
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   import knxfp_pkg::*;

   localparam int TargetOctets = 1550;
   localparam int CycleLimit   = 400000;
   localparam int HoldCycles   = 250;
   localparam int DrainCycles  = 20;

   typedef enum int {
      FRAME_GOOD,
      FRAME_BAD_SUM,
      FRAME_BAD_LEN,
      FRAME_RUNT,
      FRAME_LONG,
      FRAME_NOISE
   } frame_kind_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;   // [7:0] frame_byte
   logic        req_tlast  = 1'b0;   // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;           // result fields, status in the lowest bits

   int          failures;
   int          outstanding;
   int          octets_sent       = 0;
   int          cycle_count       = 0;
   bit          sender_quiet      = 1'b0;
   bit          receiver_quiet    = 1'b0;
   bit          hold_off_request  = 1'b0;
   logic [7:0]  frame_octets[$];

   knx_frame_parser uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   knxfp_frame_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      while (cycle_count < CycleLimit) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // append the checksum octet so that the XOR over the frame is 0xFF
   task automatic close_frame();
      logic [7:0] sum;
      sum = 8'd0;
      foreach (frame_octets[i])
         sum = sum ^ frame_octets[i];
      frame_octets.push_back(~sum);
   endtask

   // well-formed frame: header, data unit of LG+1 octets, checksum
   task automatic build_good(input logic [7:0] ctrl, input logic [15:0] src,
                             input logic [15:0] tgt, input logic [7:0] routing,
                             input logic [7:0] tpci, input logic [7:0] apci_low);
      frame_octets.delete();
      frame_octets.push_back(ctrl);
      frame_octets.push_back(src[15:8]);
      frame_octets.push_back(src[7:0]);
      frame_octets.push_back(tgt[15:8]);
      frame_octets.push_back(tgt[7:0]);
      frame_octets.push_back(routing);
      frame_octets.push_back(tpci);
      for (int i = 1; i <= int'(routing[3:0]); i++)
         frame_octets.push_back(i == 1 ? apci_low : 8'($urandom));
      close_frame();
   endtask

   task automatic build_junk(input int length, input bit valid_sum);
      frame_octets.delete();
      repeat (valid_sum ? length - 1 : length)
         frame_octets.push_back(8'($urandom));
      if (valid_sum)
         close_frame();
   endtask

   // transport octet biased towards every class
   function automatic logic [7:0] random_tpci();
      logic [7:0] t;
      t = 8'($urandom);
      case ($urandom_range(0, 7))
         0: t = CtrlConnect;
         1: t = CtrlDisconn;
         2: t = (t & ~AckMask) | CtrlAck;
         3: t = (t & ~AckMask) | CtrlNak;
         4: t = (t & ~ClassMask) | ClassData;
         5: t = (t & ~ClassMask) | ClassConnData;
         default: ;
      endcase
      return t;
   endfunction

   // mostly short data units, now and then up to the longest
   function automatic logic [7:0] random_routing();
      logic [7:0] r;
      int         pick;
      r    = 8'($urandom);
      pick = $urandom_range(0, 19);
      if (pick < 14)
         r[3:0] = 4'($urandom_range(0, 3));
      else if (pick < 19)
         r[3:0] = 4'($urandom_range(4, 8));
      else
         r[3:0] = 4'($urandom_range(9, 15));
      return r;
   endfunction

   task automatic build_random(input frame_kind_type kind);
      logic [7:0] extra;
      build_good(8'($urandom), 16'($urandom), 16'($urandom), random_routing(),
                 random_tpci(), 8'($urandom));
      case (kind)
         FRAME_BAD_SUM: begin
            extra = 8'($urandom_range(1, 255));
            frame_octets[frame_octets.size() - 1] ^= extra;
         end
         FRAME_BAD_LEN: begin
            // drop the checksum, shorten or lengthen the data unit, re-close
            void'(frame_octets.pop_back());
            if (frame_octets[5][3:0] != 4'd0 && $urandom_range(0, 1) == 0)
               void'(frame_octets.pop_back());
            else
               repeat ($urandom_range(1, 3))
                  frame_octets.push_back(8'($urandom));
            close_frame();
         end
         FRAME_RUNT:  build_junk($urandom_range(1, 7), $urandom_range(0, 1) == 1);
         FRAME_LONG:  build_junk($urandom_range(24, 45), $urandom_range(0, 3) != 0);
         FRAME_NOISE: build_junk($urandom_range(1, 30), 1'b0);
         default: ;
      endcase
   endtask

   // one octet transaction after a random gap
   task automatic send_octet(input logic [7:0] octet, input logic closing);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= octet;
      req_tlast  <= closing;
      do @(posedge clock); while (!req_tready);
      octets_sent++;
   endtask

   task automatic send_frame();
      foreach (frame_octets[i])
         send_octet(frame_octets[i], i == frame_octets.size() - 1);
   endtask

   // result side: random gaps, quiet stretches and the occasional long hold-off
   initial begin
      int gap;
      int hold_count;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         gap = receiver_quiet ? 0 : $urandom_range(0, 4);
         if (hold_off_request || gap > 0)
            rsp_tready <= 1'b0;
         if (hold_off_request) begin
            hold_count = 0;
            while (hold_count < HoldCycles) begin
               @(posedge clock);
               hold_count++;
            end
            hold_off_request = 1'b0;
         end
         repeat (gap) @(posedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // main stimulus
   initial begin
      int             frame_no;
      int             pick;
      frame_kind_type kind;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: runts
      build_junk(1, 1'b0);
      send_frame();
      build_junk(7, 1'b1);
      send_frame();
      // extremes of header fields; one-octet data unit, group
      build_good(8'hFF, 16'hFFFF, 16'hFFFF, 8'h80, ClassData, 8'h00);
      send_frame();
      build_good(8'h00, 16'h0000, 16'h0000, 8'h00, CtrlConnect, 8'h00);
      send_frame();
      // inline data: read, write, response, unknown service
      build_good(8'hB4, 16'h1203, 16'h0A05, 8'h01, 8'h00, 8'h3F);
      send_frame();
      build_good(8'hBC, 16'h1101, 16'h0901, 8'hE1, 8'h00, 8'h81);
      send_frame();
      build_good(8'hB8, 16'h11FF, 16'h0902, 8'h61, 8'h40, 8'h40);
      send_frame();
      build_good(8'hB0, 16'h1102, 16'h0903, 8'h01, 8'h7F, 8'hFF);
      send_frame();
      // remaining transport classes
      build_good(8'hB0, 16'h1104, 16'h0904, 8'h60, CtrlDisconn, 8'h00);
      send_frame();
      build_good(8'hB0, 16'h1105, 16'h0905, 8'h60, 8'hFE, 8'h00);
      send_frame();
      build_good(8'hB0, 16'h1106, 16'h0906, 8'h60, 8'hFF, 8'h00);
      send_frame();
      build_good(8'hB0, 16'h1107, 16'h0907, 8'h60, 8'hA5, 8'h00);
      send_frame();
      // longest data unit
      build_good(8'hBC, 16'hA5A5, 16'h5A5A, 8'h8F, 8'h02, 8'hC5);
      send_frame();
      // broken frames
      build_random(FRAME_BAD_SUM);
      send_frame();
      build_random(FRAME_BAD_LEN);
      send_frame();
      build_junk(40, 1'b1);
      send_frame();
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (outstanding == 0);

      // random frames
      frame_no = 0;
      while (octets_sent < TargetOctets) begin
         if (frame_no % 25 == 0) begin
            sender_quiet   = ($urandom_range(0, 3) == 0);
            receiver_quiet = ($urandom_range(0, 3) == 0);
         end
         // result side blocks for a long stretch while octets keep coming
         if (frame_no == 40 || frame_no == 130) begin
            hold_off_request = 1'b1;
            sender_quiet     = 1'b1;
         end
         // sender waits for every outstanding result
         if (frame_no % 30 == 29) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            wait (outstanding == 0);
         end
         pick = $urandom_range(0, 99);
         if (pick < 60)
            kind = FRAME_GOOD;
         else if (pick < 70)
            kind = FRAME_BAD_SUM;
         else if (pick < 80)
            kind = FRAME_BAD_LEN;
         else if (pick < 88)
            kind = FRAME_RUNT;
         else if (pick < 93)
            kind = FRAME_LONG;
         else
            kind = FRAME_NOISE;
         build_random(kind);
         send_frame();
         frame_no++;
      end
      req_tvalid <= 1'b0;

      // drain and verdict
      @(posedge clock);
      wait (outstanding == 0);
      repeat (DrainCycles) @(posedge clock);
      if (failures == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
